/* hdl/ppm_pkg.sv */
// ---------------------------------------------------------------------------
// PPM frame decoder package
// Shared types, constants and register indices for the PPM frame decoder.
// ---------------------------------------------------------------------------
package ppm_pkg;

    // Decoder limits and fixed constants
    localparam int unsigned MAX_CHANNELS  = 12;
    localparam int unsigned SLOT_W        = 4;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned BUCKET_W      = 6;
    localparam logic [12:0] VALUE_OFFSET  = 13'd1000;
    localparam logic [11:0] VALUE_MAX     = 12'd2047;

    // Configuration register indices
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAD_PENALTY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_LIMIT   = 3'd5;

    // Request opcodes
    localparam logic OP_EDGE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // Configuration set
    typedef struct packed {
        logic [15:0] sync_threshold;
        logic [11:0] min_width;
        logic [11:0] max_width;
        logic [3:0]  channel_count;
        logic [4:0]  bad_penalty;
        logic [4:0]  bucket_limit;
    } t_ppm_cfg;

    // Input request
    typedef struct packed {
        logic        opcode;
        logic [31:0] edge_time;
    } t_ppm_in;

    // Result
    typedef struct packed {
        logic [3:0]         channel_slot;
        logic signed [11:0] channel_value;
        logic               value_written;
        logic               sync_seen;
        logic               frame_done;
        logic               frame_good;
        logic               fresh_values;
        logic               signal_ok;
        logic [15:0]        glitch_total;
        logic [23:0]        sync_pause;
        logic               rearm_timeout;
    } t_ppm_out;

endpackage

/* hdl/ppm_cfg_regs.sv */
// ---------------------------------------------------------------------------
// PPM configuration registers
// Write-only register bank holding the decoder thresholds and limits.
// ---------------------------------------------------------------------------
module ppm_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ppm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output ppm_pkg::t_ppm_cfg                o_cfg
);

    ppm_pkg::t_ppm_cfg r_cfg;

    // Register write decode; unknown indices are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_threshold <= 16'd2400;
            r_cfg.min_width      <= 12'd800;
            r_cfg.max_width      <= 12'd2200;
            r_cfg.channel_count  <= 4'd8;
            r_cfg.bad_penalty    <= 5'd4;
            r_cfg.bucket_limit   <= 5'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ppm_pkg::REG_SYNC_THRESHOLD: r_cfg.sync_threshold <= i_cfg_data;
                ppm_pkg::REG_MIN_WIDTH:      r_cfg.min_width      <= i_cfg_data[11:0];
                ppm_pkg::REG_MAX_WIDTH:      r_cfg.max_width      <= i_cfg_data[11:0];
                ppm_pkg::REG_CHANNEL_COUNT:  r_cfg.channel_count  <= i_cfg_data[3:0];
                ppm_pkg::REG_BAD_PENALTY:    r_cfg.bad_penalty    <= i_cfg_data[4:0];
                ppm_pkg::REG_BUCKET_LIMIT:   r_cfg.bucket_limit   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/ppm_decode_core.sv */
// ---------------------------------------------------------------------------
// PPM decode core
// Frame state and single-pass decode of one edge or timeout request.
// ---------------------------------------------------------------------------
module ppm_decode_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  ppm_pkg::t_ppm_in   i_item,
    input  ppm_pkg::t_ppm_cfg  i_cfg,
    output ppm_pkg::t_ppm_out  o_result
);

    // Frame state
    logic [31:0]                     r_prev_edge, n_prev_edge;
    logic [ppm_pkg::SLOT_W-1:0]      r_slot, n_slot;
    logic                            r_clean, n_clean;
    logic                            r_fresh, n_fresh;
    logic                            r_sig, n_sig;
    logic signed [ppm_pkg::BUCKET_W-1:0] r_bucket, n_bucket;
    logic [15:0]                     r_glitch, n_glitch;
    logic [23:0]                     r_pause, n_pause;

    // Datapath
    logic [31:0]        width;
    logic [3:0]         count;
    logic [3:0]         slot_inc;
    logic               in_range;
    logic signed [12:0] raw_value;
    logic signed [7:0]  lim_pos, lim_neg, bucket_ext, bucket_sum;

    assign width     = i_item.edge_time - r_prev_edge;
    assign count     = (i_cfg.channel_count > 4'(ppm_pkg::MAX_CHANNELS))
                     ? 4'(ppm_pkg::MAX_CHANNELS) : i_cfg.channel_count;
    assign slot_inc  = r_slot + 4'd1;
    assign in_range  = (width >= {20'd0, i_cfg.min_width})
                    && (width <= {20'd0, i_cfg.max_width});
    // in range implies width below 4096
    assign raw_value = $signed({1'b0, width[11:0]}) - $signed(ppm_pkg::VALUE_OFFSET);
    assign lim_pos   = $signed({3'b000, i_cfg.bucket_limit});
    assign lim_neg   = -lim_pos;
    assign bucket_ext = 8'(r_bucket);

    // Next-state and result logic
    always_comb begin
        n_prev_edge = r_prev_edge;
        n_slot      = r_slot;
        n_clean     = r_clean;
        n_fresh     = r_fresh;
        n_sig       = r_sig;
        n_bucket    = r_bucket;
        n_glitch    = r_glitch;
        n_pause     = r_pause;
        bucket_sum  = bucket_ext;

        o_result               = '0;
        o_result.channel_slot  = r_slot;

        if (i_item.opcode == ppm_pkg::OP_TIMEOUT) begin
            if (r_sig) begin
                n_sig    = 1'b0;
                n_bucket = lim_neg[ppm_pkg::BUCKET_W-1:0];
            end
        end else begin
            n_prev_edge = i_item.edge_time;
            if (width > {16'd0, i_cfg.sync_threshold}) begin
                // sync pause: restart the frame
                n_slot                = '0;
                o_result.channel_slot = '0;
                n_clean               = 1'b1;
                n_fresh               = 1'b0;
                n_pause               = (width[31:24] != 8'd0) ? 24'hFF_FFFF : width[23:0];
                o_result.sync_seen    = 1'b1;
            end else if (r_slot < count) begin
                if (in_range) begin
                    o_result.channel_value = (raw_value > $signed({1'b0, ppm_pkg::VALUE_MAX}))
                                           ? $signed(ppm_pkg::VALUE_MAX) : raw_value[11:0];
                    o_result.value_written = 1'b1;
                end else begin
                    n_glitch = r_glitch + 16'd1;
                    n_clean  = 1'b0;
                end
                n_slot = slot_inc;
                // last slot: update the signal bucket
                if (slot_inc == count) begin
                    if (n_clean) begin
                        n_fresh    = 1'b1;
                        bucket_sum = bucket_ext + 8'sd1;
                    end else begin
                        n_fresh    = 1'b0;
                        bucket_sum = bucket_ext - $signed({3'b000, i_cfg.bad_penalty});
                    end
                    if (bucket_sum > lim_pos) begin
                        bucket_sum = lim_pos;
                    end
                    if (bucket_sum < lim_neg) begin
                        bucket_sum = lim_neg;
                    end
                    n_bucket               = bucket_sum[ppm_pkg::BUCKET_W-1:0];
                    n_sig                  = (bucket_sum > 8'sd0);
                    o_result.frame_done    = 1'b1;
                    o_result.rearm_timeout = 1'b1;
                end
            end
        end

        o_result.frame_good   = n_clean;
        o_result.fresh_values = n_fresh;
        o_result.signal_ok    = n_sig;
        o_result.glitch_total = n_glitch;
        o_result.sync_pause   = n_pause;
    end

    // State update on each decoded request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_edge <= '0;
            r_slot      <= '0;
            r_clean     <= 1'b0;
            r_fresh     <= 1'b0;
            r_sig       <= 1'b0;
            r_bucket    <= '0;
            r_glitch    <= '0;
            r_pause     <= '0;
        end else if (i_step) begin
            r_prev_edge <= n_prev_edge;
            r_slot      <= n_slot;
            r_clean     <= n_clean;
            r_fresh     <= n_fresh;
            r_sig       <= n_sig;
            r_bucket    <= n_bucket;
            r_glitch    <= n_glitch;
            r_pause     <= n_pause;
        end
    end

endmodule

/* hdl/ppm_frame_decoder_top.sv */
// ---------------------------------------------------------------------------
// PPM frame decoder top level
// Input register, decode core and result register for an RC PPM stream.
// ---------------------------------------------------------------------------
// Each request (an edge timestamp or a timeout) gives exactly one result.
// A request passes an input register and a result register. o_out_valid rises
// once the request moves from the input register into the result register;
// that move waits while an untaken result is held. One request is taken every
// cycle while the result side keeps draining; the combinational decode core
// between the two registers sets that rate. Write configuration only while no
// request is in flight.
module ppm_frame_decoder_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ppm_pkg::t_ppm_in                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ppm_pkg::t_ppm_out               o_out_data,
    input  logic                            i_cfg_we,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ppm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ppm_pkg::t_ppm_cfg cfg;
    ppm_pkg::t_ppm_in  r_in_data;
    ppm_pkg::t_ppm_out r_out_data;
    ppm_pkg::t_ppm_out core_result;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              out_free;
    logic              move;

    // Pipeline flow control
    assign out_free   = !r_out_valid || i_out_ready;
    assign move       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || move;

    ppm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ppm_decode_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (move),
        .i_item   (r_in_data),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_data <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
